@@ design/g2pwr_pkg.sv @@
// Shared types, constants and the font table of the glyph rasterizer.
`default_nettype none

package g2pwr_pkg;

  // Glyph geometry used by the scan.
  localparam int GLYPH_COLUMNS = 6;
  localparam int GLYPH_ROWS    = 8;
  localparam int GLYPH_COUNT   = 96;

  // Geometry of the stored font table.
  localparam int ROM_GLYPHS   = 96;
  localparam int ROM_COLS     = 6;
  localparam int ROM_COL_BITS = 8;

  localparam int BITMAP_W = GLYPH_COLUMNS * GLYPH_ROWS;
  localparam int COL_W    = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
  localparam int ROW_W    = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  localparam int CODE_W   = 8;
  localparam int GLYPH_W  = 7;
  localparam int COORD_W  = 8;
  localparam int DISP_W   = 10;
  localparam int COLOR_W  = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GLYPH_W-1:0] SPACE_CODE = 7'h20;
  localparam logic [DISP_W-1:0]  WINDOW_SPAN = 10'd2;

  // Reset values of the configuration registers.
  localparam logic [COORD_W-1:0] COLUMN_ORIGIN_RST = 8'h34;
  localparam logic [COORD_W-1:0] ROW_ORIGIN_RST    = 8'h28;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST    = 16'hFFE0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_ORIGIN = 2'd0,
    REG_ROW_ORIGIN    = 2'd1,
    REG_FILL_COLOR    = 2'd2
  } cfg_reg_t;

  // Configuration as seen by the scan engine.
  typedef struct packed {
    logic [COORD_W-1:0] column_origin;
    logic [COORD_W-1:0] row_origin;
    logic [COLOR_W-1:0] fill_color;
  } cfg_t;

  // One classified character waiting for the scan engine.
  typedef struct packed {
    logic [BITMAP_W-1:0] bitmap;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
  } job_t;

  // Font table: column 0 in the lowest byte, bit 0 of a byte is the top row.
  localparam logic [ROM_COLS*ROM_COL_BITS-1:0] GLYPH_TABLE [ROM_GLYPHS] = '{
    48'h000000000000, 48'h00000000002f, 48'h000000030003, 48'h123f12123f12,
    48'h003a2a7f2a2e, 48'h313204081323, 48'h20102a252a10, 48'h000000000102,
    48'h00000000211e, 48'h000000001e21, 48'h08082a1c2a08, 48'h0808083e0808,
    48'h000000006080, 48'h000808080808, 48'h000000003030, 48'h000204081020,
    48'h1e232529311e, 48'h2020203f2122, 48'h262929292932, 48'h1a2525212112,
    48'h10103f121418, 48'h192525252517, 48'h18252525251e, 48'h030509310101,
    48'h1a252525251a, 48'h1e2929292906, 48'h000000000024, 48'h000000006480,
    48'h000000221408, 48'h001414141414, 48'h000000081422, 48'h020529010102,
    48'h0e2d2b2d211e, 48'h3e090909093e, 48'h1a252525253f, 48'h12212121211e,
    48'h0c122121213f, 48'h21252525253f, 48'h01050505053f, 48'h1a292121211e,
    48'h3f040404043f, 48'h2121213f2121, 48'h1f2020202010, 48'h20110a0c043f,
    48'h20202020203f, 48'h3f020404023f, 48'h3f100804023f, 48'h1e212121211e,
    48'h06090909093f, 48'h1e213129211e, 48'h26190909093f, 48'h182525252512,
    48'h01013f010101, 48'h1f202020201f, 48'h0f102020100f, 48'h1f201010201f,
    48'h21120c0c1221, 48'h0204380c0201, 48'h212325293121, 48'h00000000213f,
    48'h002010080402, 48'h000000003f21, 48'h0004023f0204, 48'h404040404040,
    48'h000000000201, 48'h003c2a2a3010, 48'h00182424243f, 48'h00002222140c,
    48'h003f24242418, 48'h00242a2a2c1c, 48'h00000001053e, 48'h007ca4a42818,
    48'h00300c04043f, 48'h000000203d24, 48'h00003d404020, 48'h000020120c3f,
    48'h00000020201f, 48'h003c023c023e, 48'h003c0202023e, 48'h000c3222140c,
    48'h0018242424fc, 48'h80fc24242418, 48'h00000202043c, 48'h00102a2a2c24,
    48'h000020221f02, 48'h001e2020201e, 48'h000618201806, 48'h000e301c301e,
    48'h002214081422, 48'h007ca0a0100c, 48'h2222262a3222, 48'h000000213f0c,
    48'h00000000003f, 48'h0000000c3f21, 48'h000001020102, 48'h000000000000
  };

  // Gathers the scanned bits of one glyph, column-major; absent bytes read as zero.
  function automatic logic [BITMAP_W-1:0] glyph_bitmap(input logic [GLYPH_W-1:0] glyph);
    logic [BITMAP_W-1:0]              bits;
    logic [ROM_COLS*ROM_COL_BITS-1:0] entry;
    bits  = '0;
    entry = '0;
    if ((int'(glyph) < ROM_GLYPHS) && (int'(glyph) < GLYPH_COUNT)) begin
      entry = GLYPH_TABLE[glyph];
    end
    for (int c = 0; c < GLYPH_COLUMNS; c++) begin
      for (int b = 0; b < GLYPH_ROWS; b++) begin
        if ((c < ROM_COLS) && (b < ROM_COL_BITS)) begin
          bits[c*GLYPH_ROWS+b] = entry[c*ROM_COL_BITS+b];
        end
      end
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

@@ design/g2pwr_front.sv @@
// Front end: accepts characters, looks up their glyph and drops blank ones.
`default_nettype none

module g2pwr_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata fields from bit 0: char_code[7:0], cell_x[15:8], cell_y[23:16]
  input  wire logic [g2pwr_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output g2pwr_pkg::job_t                          q_job
);

  logic [g2pwr_pkg::CODE_W-1:0]   char_code;
  logic [g2pwr_pkg::GLYPH_W-1:0]  code7;
  logic [g2pwr_pkg::GLYPH_W-1:0]  glyph;
  logic [g2pwr_pkg::BITMAP_W-1:0] bitmap;
  logic                           accept;

  // Unpack the transfer.
  assign char_code    = in_tdata[7:0];
  assign q_job.cell_x = in_tdata[15:8];
  assign q_job.cell_y = in_tdata[23:16];

  // Control codes share the blank glyph; printable codes are offset by space.
  assign code7  = char_code[g2pwr_pkg::GLYPH_W-1:0];
  assign glyph  = (code7 >= g2pwr_pkg::SPACE_CODE) ? (code7 - g2pwr_pkg::SPACE_CODE) : '0;
  assign bitmap = g2pwr_pkg::glyph_bitmap(glyph);
  assign q_job.bitmap = bitmap;

  // A blank glyph produces no windows, so it is consumed without a queue slot.
  assign in_tready = ~q_full;
  assign accept    = in_tvalid & in_tready;
  assign q_push    = accept & (bitmap != '0);

`ifndef NO_ASSERTIONS
  // The queue is never written while it has no room.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");
  // Every queued job carries at least one lit pixel.
  a_push_lit: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_job.bitmap != '0)) else $error("blank glyph queued");
  // A character is taken only while a slot is free.
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !q_full) else $error("accept without room");
`endif

endmodule

`default_nettype wire

@@ design/g2pwr_queue.sv @@
// Short job queue between the front end and the scan engine.
`default_nettype none

module g2pwr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire g2pwr_pkg::job_t push_job,
  output logic                 full,
  output logic                 valid,
  output g2pwr_pkg::job_t      head_job,
  input  wire logic            pop
);

  g2pwr_pkg::job_t                  slot_r [g2pwr_pkg::QUEUE_DEPTH];
  logic [g2pwr_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [g2pwr_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [g2pwr_pkg::QCNT_W-1:0]     count_r,  count_nxt;
  logic                             do_push, do_pop;

  assign full     = (count_r == g2pwr_pkg::QCNT_W'(g2pwr_pkg::QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign head_job = slot_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ design/g2pwr_back.sv @@
// Scan engine: walks a glyph one pixel per cycle while the output register does not stall it, and emits lit windows.
`default_nettype none

module g2pwr_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire g2pwr_pkg::cfg_t                   cfg,
  input  wire logic                              q_valid,
  input  wire g2pwr_pkg::job_t                   q_job,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata fields from bit 0: col_first[9:0], col_final[19:10], row_first[29:20],
  // row_final[39:30], pixel_color[55:40]
  output logic [g2pwr_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                   out_tlast
);

  logic                                busy_r,      busy_nxt;
  logic [g2pwr_pkg::BITMAP_W-1:0]      rem_r,       rem_nxt;
  logic [g2pwr_pkg::COL_W-1:0]         col_r,       col_nxt;
  logic [g2pwr_pkg::ROW_W-1:0]         bit_r,       bit_nxt;
  logic [g2pwr_pkg::COORD_W-1:0]       cx_r,        cx_nxt;
  logic [g2pwr_pkg::COORD_W-1:0]       cy_r,        cy_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [g2pwr_pkg::OUT_DATA_W-1:0]    out_data_r,  out_data_nxt;
  logic                                out_last_r,  out_last_nxt;

  logic                                advance;
  logic [g2pwr_pkg::BITMAP_W-1:0]      rem_shift;
  logic [g2pwr_pkg::COORD_W-1:0]       x_sum, y_sum;
  logic [g2pwr_pkg::DISP_W-1:0]        col_first, col_final, row_first, row_final;

  // Window coordinates of the current scan position.
  assign x_sum     = cx_r + g2pwr_pkg::COORD_W'(bit_r);
  assign y_sum     = cy_r + g2pwr_pkg::COORD_W'(col_r);
  assign col_first = {2'b00, cfg.column_origin} + {1'b0, x_sum, 1'b0};
  assign row_first = {2'b00, cfg.row_origin} + {1'b0, y_sum, 1'b0};
  assign col_final = col_first + g2pwr_pkg::WINDOW_SPAN;
  assign row_final = row_first + g2pwr_pkg::WINDOW_SPAN;

  assign rem_shift = rem_r >> 1;
  assign advance   = ~out_valid_r | out_tready;
  assign q_pop     = ~busy_r & q_valid;

  // Scan control and output register loading.
  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    col_nxt       = col_r;
    bit_nxt       = bit_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (q_pop) begin
      busy_nxt = 1'b1;
      rem_nxt  = q_job.bitmap;
      cx_nxt   = q_job.cell_x;
      cy_nxt   = q_job.cell_y;
      col_nxt  = '0;
      bit_nxt  = '0;
    end else if (busy_r && advance) begin
      if (rem_r[0]) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {cfg.fill_color, row_final, row_first, col_final, col_first};
        out_last_nxt  = (rem_shift == '0);
      end
      rem_nxt = rem_shift;
      if (rem_shift == '0) begin
        busy_nxt = 1'b0;
      end
      if (bit_r == g2pwr_pkg::ROW_W'(g2pwr_pkg::GLYPH_ROWS - 1)) begin
        bit_nxt = '0;
        col_nxt = col_r + 1'b1;
      end else begin
        bit_nxt = bit_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Position and payload registers.
  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    bit_r      <= bit_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // The engine is busy exactly while unscanned lit pixels remain.
  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (rem_r != '0)) else $error("busy flag out of step with bitmap");
  // A new job is taken only when it has lit pixels.
  a_pop_lit: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_job.bitmap != '0)) else $error("blank job popped");
  // The scan never runs past the last glyph column.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (col_r <= g2pwr_pkg::COL_W'(g2pwr_pkg::GLYPH_COLUMNS - 1)))
    else $error("column counter out of range");
  // A window that is not the last of its glyph means the scan is still going.
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> busy_r) else $error("glyph ended without last");
`endif

endmodule

`default_nettype wire

@@ design/glyph_to_pixel_window_rasterizer.sv @@
// Top level of the glyph rasterizer: configuration registers and block wiring.
//
// Each accepted character produces one 3x3 display window per lit pixel of its
// 6x8 glyph, scanned column by column and within a column from bit 0 up, with
// the last window of the character flagged on out_tlast; blank glyphs produce
// nothing. The front end looks up a character's glyph combinationally and places
// it in a two-entry job queue. The scan engine steps through one pixel position
// per cycle while the output register does not stall it, and stops after the last
// lit one. Configuration writes take effect at once and are always ready.
`default_nettype none

module glyph_to_pixel_window_rasterizer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata fields from bit 0: char_code[7:0], cell_x[15:8], cell_y[23:16]
  input  wire logic [g2pwr_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // tdata fields from bit 0: col_first[9:0], col_final[19:10], row_first[29:20],
  // row_final[39:30], pixel_color[55:40]
  output logic [g2pwr_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [g2pwr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [g2pwr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  g2pwr_pkg::cfg_t  cfg_r, cfg_nxt;
  g2pwr_pkg::job_t  push_job, head_job;
  logic             q_push, q_full, q_valid, q_pop;

  // Register writes; an index outside the list is ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        g2pwr_pkg::REG_COLUMN_ORIGIN: cfg_nxt.column_origin = cfg_data[7:0];
        g2pwr_pkg::REG_ROW_ORIGIN:    cfg_nxt.row_origin    = cfg_data[7:0];
        g2pwr_pkg::REG_FILL_COLOR:    cfg_nxt.fill_color    = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_origin <= g2pwr_pkg::COLUMN_ORIGIN_RST;
      cfg_r.row_origin    <= g2pwr_pkg::ROW_ORIGIN_RST;
      cfg_r.fill_color    <= g2pwr_pkg::FILL_COLOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Character intake and glyph lookup.
  g2pwr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Decoupling queue.
  g2pwr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .valid    (q_valid),
    .head_job (head_job),
    .pop      (q_pop)
  );

  // Pixel scan and window output.
  g2pwr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ bench/g2pwr_window_board_pkg.sv @@
// Scoreboard for the glyph rasterizer bench: font copy, window prediction and result checks.
`timescale 1ns / 1ps

package g2pwr_window_board_pkg;
  import g2pwr_pkg::*;

  localparam logic [7:0]           CODE_MASK          = 8'h7F;
  localparam logic [7:0]           FIRST_PRINTABLE    = 8'h20;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG       = 2'd3;
  localparam int                   MAX_PRINTED_ERRORS = 40;

  // Result word as it travels on out_tdata, col_first in the lowest bits.
  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [DISP_W-1:0]  row_final;
    logic [DISP_W-1:0]  row_first;
    logic [DISP_W-1:0]  col_final;
    logic [DISP_W-1:0]  col_first;
  } window_data_t;

  typedef struct packed {
    logic         end_of_glyph;
    window_data_t data;
  } window_t;

  // Font in reading order: the leftmost byte is glyph column 0, bit 0 is the top row.
  localparam logic [47:0] FONT_BYTES [96] = '{
    48'h000000000000, 48'h2f0000000000, 48'h030003000000, 48'h123f12123f12,
    48'h2e2a7f2a3a00, 48'h231308043231, 48'h102a252a1020, 48'h020100000000,
    48'h1e2100000000, 48'h211e00000000, 48'h082a1c2a0808, 48'h08083e080808,
    48'h806000000000, 48'h080808080800, 48'h303000000000, 48'h201008040200,
    48'h1e312925231e, 48'h22213f202020, 48'h322929292926, 48'h12212125251a,
    48'h1814123f1010, 48'h172525252519, 48'h1e2525252518, 48'h010131090503,
    48'h1a252525251a, 48'h06292929291e, 48'h240000000000, 48'h806400000000,
    48'h081422000000, 48'h141414141400, 48'h221408000000, 48'h020101290502,
    48'h1e212d2b2d0e, 48'h3e090909093e, 48'h3f252525251a, 48'h1e2121212112,
    48'h3f212121120c, 48'h3f2525252521, 48'h3f0505050501, 48'h1e212121291a,
    48'h3f040404043f, 48'h21213f212121, 48'h10202020201f, 48'h3f040c0a1120,
    48'h3f2020202020, 48'h3f020404023f, 48'h3f020408103f, 48'h1e212121211e,
    48'h3f0909090906, 48'h1e212931211e, 48'h3f0909091926, 48'h122525252518,
    48'h0101013f0101, 48'h1f202020201f, 48'h0f102020100f, 48'h1f201010201f,
    48'h21120c0c1221, 48'h01020c380402, 48'h213129252321, 48'h3f2100000000,
    48'h020408102000, 48'h213f00000000, 48'h04023f020400, 48'h404040404040,
    48'h010200000000, 48'h10302a2a3c00, 48'h3f2424241800, 48'h0c1422220000,
    48'h182424243f00, 48'h1c2c2a2a2400, 48'h3e0501000000, 48'h1828a4a47c00,
    48'h3f04040c3000, 48'h243d20000000, 48'h2040403d0000, 48'h3f0c12200000,
    48'h1f2020000000, 48'h3e023c023c00, 48'h3e0202023c00, 48'h0c1422320c00,
    48'hfc2424241800, 48'h18242424fc80, 48'h3c0402020000, 48'h242c2a2a1000,
    48'h021f22200000, 48'h1e2020201e00, 48'h061820180600, 48'h1e301c300e00,
    48'h221408142200, 48'h0c10a0a07c00, 48'h22322a262222, 48'h0c3f21000000,
    48'h3f0000000000, 48'h213f0c000000, 48'h020102010000, 48'h000000000000
  };

  class glyph_window_board;
    window_t            windows_due[$];
    logic [COORD_W-1:0] column_origin;
    logic [COORD_W-1:0] row_origin;
    logic [COLOR_W-1:0] fill_color;
    int                 mismatches;
    int                 chars_noted;
    int                 blank_chars;
    int                 windows_checked;
    int                 settings_used;

    function new();
      column_origin   = 8'h34;
      row_origin      = 8'h28;
      fill_color      = 16'hFFE0;
      mismatches      = 0;
      chars_noted     = 0;
      blank_chars     = 0;
      windows_checked = 0;
      settings_used   = 1;
    endfunction

    // Mirror of a register write; unknown indexes and bits above a register's width drop out.
    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_COLUMN_ORIGIN: column_origin = value[COORD_W-1:0];
        REG_ROW_ORIGIN:    row_origin    = value[COORD_W-1:0];
        REG_FILL_COLOR:    fill_color    = value[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Expands one accepted character into the windows it must produce, in scan order.
    function void note_char(logic [IN_DATA_W-1:0] word);
      logic [7:0]         code;
      logic [6:0]         glyph;
      logic [47:0]        font_row;
      logic [7:0]         column_bits;
      logic [COORD_W-1:0] x_step;
      logic [COORD_W-1:0] y_step;
      logic [DISP_W-1:0]  row_start;
      logic [DISP_W-1:0]  col_start;
      window_t            held;
      bit                 have_held;
      code      = word[7:0] & CODE_MASK;
      glyph     = (code >= FIRST_PRINTABLE) ? 7'(code - FIRST_PRINTABLE) : 7'd0;
      font_row  = FONT_BYTES[glyph];
      have_held = 1'b0;
      held      = '0;
      chars_noted++;
      for (int c = 0; c < GLYPH_COLUMNS; c++) begin
        column_bits = font_row[47 - 8*c -: 8];
        y_step      = word[23:16] + COORD_W'(c);
        row_start   = DISP_W'(row_origin) + DISP_W'({y_step, 1'b0});
        for (int b = 0; b < GLYPH_ROWS; b++) begin
          if (column_bits[b]) begin
            // Hold one window back so the final one can carry the end flag.
            if (have_held) begin
              windows_due.push_back(held);
            end
            x_step                 = word[15:8] + COORD_W'(b);
            col_start              = DISP_W'(column_origin) + DISP_W'({x_step, 1'b0});
            held.end_of_glyph      = 1'b0;
            held.data.col_first    = col_start;
            held.data.col_final    = col_start + DISP_W'(2);
            held.data.row_first    = row_start;
            held.data.row_final    = row_start + DISP_W'(2);
            held.data.pixel_color  = fill_color;
            have_held              = 1'b1;
          end
        end
      end
      if (have_held) begin
        held.end_of_glyph = 1'b1;
        windows_due.push_back(held);
      end else begin
        blank_chars++;
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED_ERRORS) begin
        $display("[%0t] window %0d: %s", $time, windows_checked, what);
      end
    endtask

    task check_field(string name, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
      if (got !== want) begin
        report($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
      end
    endtask

    // Compares one result transfer with the oldest predicted window.
    task check_window(window_t got);
      window_t want;
      if (windows_due.size() == 0) begin
        report($sformatf("unpredicted window at column %0d row %0d",
                         got.data.col_first, got.data.row_first));
        return;
      end
      want = windows_due.pop_front();
      windows_checked++;
      check_field("col_first", got.data.col_first, want.data.col_first);
      check_field("col_final", got.data.col_final, want.data.col_final);
      check_field("row_first", got.data.row_first, want.data.row_first);
      check_field("row_final", got.data.row_final, want.data.row_final);
      check_field("pixel_color", got.data.pixel_color, want.data.pixel_color);
      check_field("end_of_glyph", got.end_of_glyph, want.end_of_glyph);
    endtask

    task close_out();
      if (windows_due.size() != 0) begin
        report($sformatf("%0d predicted windows never arrived", windows_due.size()));
      end
    endtask
  endclass

endpackage

@@ bench/tb_glyph_to_pixel_window_rasterizer.sv @@
// Testbench top: streams characters and register writes into the rasterizer and checks each window.
`timescale 1ns / 1ps

module tb_glyph_to_pixel_window_rasterizer;
  import g2pwr_pkg::*;
  import g2pwr_window_board_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 150;
  localparam int RANDOM_PHASES   = 6;
  localparam int CHARS_PER_PHASE = 50;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  gaps_on    = 1'b1;
  int                    idle_cycles = 0;

  glyph_window_board board = new();

  always #1 clk = ~clk;

  glyph_to_pixel_window_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Every result transfer is checked against the oldest predicted window.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_window(window_t'({out_tlast, out_tdata}));
    end
  end

  // Watchdog: the run ends if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each transfer, none while gaps are off.
  initial begin : result_sink
    int stall;
    forever begin
      @(negedge clk);
      stall = gaps_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid && out_tready));
    end
  end

  // Offers one character after a random gap and notes it once the transfer happens.
  task automatic send_char(input logic [7:0] code, input logic [7:0] x, input logic [7:0] y);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x, code};
    do @(posedge clk); while (!in_tready);
    board.note_char({y, x, code});
  endtask

  // Mostly printable glyphs with a random top bit; the rest is any byte at all.
  task automatic send_random_char();
    logic [7:0] code;
    logic [7:0] x;
    logic [7:0] y;
    if ($urandom_range(0, 99) < 85) begin
      code = {1'($urandom_range(0, 1)),
              7'($urandom_range(FIRST_PRINTABLE + 1, CODE_MASK - 1))};
    end else begin
      code = 8'($urandom());
    end
    // Cells near the top of the range exercise the modulo-256 wrap.
    x = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(246, 255)) : 8'($urandom());
    y = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(248, 255)) : 8'($urandom());
    send_char(code, x, y);
  endtask

  // Drops valid, then lets every predicted window drain and blank characters finish.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.windows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(input logic [CFG_DATA_W-1:0] col_origin,
                              input logic [CFG_DATA_W-1:0] row_origin,
                              input logic [CFG_DATA_W-1:0] color);
    set_register(REG_COLUMN_ORIGIN, col_origin);
    set_register(REG_ROW_ORIGIN, row_origin);
    set_register(REG_FILL_COLOR, color);
    board.settings_used++;
  endtask

  initial begin : stimulus
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed characters under the reset setting: blanks, masking, wrap and edge rows.
    send_char(8'h00, 8'h00, 8'h00);
    send_char(8'h1F, 8'hFF, 8'hFF);
    send_char(8'h20, 8'h80, 8'h7F);
    send_char(8'h7F, 8'h55, 8'hAA);
    send_char(8'h80, 8'h00, 8'h00);
    send_char(8'hFF, 8'hFF, 8'h00);
    send_char(8'h41, 8'h00, 8'h00);
    send_char(8'hC1, 8'hFF, 8'hFF);
    send_char(8'h23, 8'hFA, 8'hFB);
    send_char(8'h2C, 8'h7F, 8'h80);
    send_char(8'h71, 8'hF9, 8'hFE);
    send_char(8'h5F, 8'h01, 8'h02);
    send_char(8'h40, 8'hAA, 8'h55);
    send_char(8'h21, 8'hFF, 8'h00);
    send_char(8'h7E, 8'h00, 8'hFF);
    send_char(8'h57, 8'h0F, 8'hF0);
    send_char(8'hBA, 8'hF0, 8'h0F);
    settle();

    // Lowest setting, then highest with extra high bits and a write to the unused index.
    load_setting(16'h0000, 16'h0000, 16'h0000);
    send_char(8'h41, 8'hFF, 8'hFF);
    send_char(8'h23, 8'h00, 8'h00);
    send_char(8'h71, 8'h80, 8'h7F);
    settle();
    load_setting(16'hA5FF, 16'h5AFF, 16'hFFFF);
    set_register(UNMAPPED_REG, 16'h1234);
    send_char(8'h23, 8'hFF, 8'hFF);
    send_char(8'hC7, 8'hFC, 8'h03);
    send_char(8'h2C, 8'hFE, 8'hFA);
    settle();

    // Random phases, each under a new setting; one phase runs with no idling at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gaps_on = (p != 2);
      load_setting(16'($urandom()), 16'($urandom()), 16'($urandom()));
      if ($urandom_range(0, 1) == 1) begin
        set_register(UNMAPPED_REG, 16'($urandom()));
      end
      repeat (CHARS_PER_PHASE) send_random_char();
      settle();
    end

    board.close_out();
    $display("Sent %0d characters (%0d blank) under %0d register settings;",
             board.chars_noted, board.blank_chars, board.settings_used);
    $display("%0d windows checked, %0d mismatches.", board.windows_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
